[design/hvt_pkg.sv]
// hvt_pkg: shared types and constants for the homogeneous vertex transform.
// No dependencies.
package hvt_pkg;

  localparam int CoefW  = 16;
  localparam int CoordW = 32;
  localparam int ProdW  = 48;
  localparam int RowW   = 50;
  localparam int MagW   = 48;
  localparam int QW     = 32;
  localparam int NumDivSteps = 32;
  localparam int CfgIdxW = 3;

  localparam logic [63:0] ResetCol0 = 64'h0000_0000_0000_1000;
  localparam logic [63:0] ResetCol1 = 64'h0000_0000_1000_0000;
  localparam logic [63:0] ResetCol2 = 64'h0000_1000_0000_0000;
  localparam logic [63:0] ResetCol3 = 64'h1000_0000_0000_0000;

  localparam logic [CfgIdxW-1:0] RegCol0 = 3'd0;
  localparam logic [CfgIdxW-1:0] RegCol1 = 3'd1;
  localparam logic [CfgIdxW-1:0] RegCol2 = 3'd2;
  localparam logic [CfgIdxW-1:0] RegCol3 = 3'd3;

  localparam logic [1:0] StatusOk    = 2'd0;
  localparam logic [1:0] StatusSat   = 2'd1;
  localparam logic [1:0] StatusWZero = 2'd2;

  localparam logic [QW-1:0] QMaxPos = 32'h7FFF_FFFF;
  localparam logic [QW-1:0] QMaxNeg = 32'h8000_0000;

  typedef struct packed {
    logic signed [RowW-1:0] r0;
    logic signed [RowW-1:0] r1;
    logic signed [RowW-1:0] r2;
    logic signed [RowW-1:0] r3;
  } rows_t;

  typedef struct packed {
    logic [MagW-1:0] rem;
    logic [QW-1:0]   nlo;
    logic [QW-1:0]   q;
    logic            neg;
    logic            ovf;
    logic            npos;
    logic            nneg;
  } lane_t;

  typedef struct packed {
    lane_t [2:0]     lane;
    logic [MagW-1:0] d;
    logic            wz;
    logic            last;
  } div_item_t;

endpackage

[design/hvt_mac.sv]
// hvt_mac: two-stage matrix multiply; products, then row sums.
// Depends on hvt_pkg.
module hvt_mac import hvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     ce,
  input  logic                     valid_in,
  input  logic signed [CoordW-1:0] x,
  input  logic signed [CoordW-1:0] y,
  input  logic signed [CoordW-1:0] z,
  input  logic                     last_in,
  input  logic [3:0][63:0]         matrix,
  output logic                     valid_out,
  output rows_t                    rows,
  output logic                     last_out
);

  logic signed [ProdW-1:0] prod [4][3];
  logic signed [CoordW-1:0] trans [4];
  logic v1, last1;
  logic signed [RowW-1:0] sums [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      valid_out <= 1'b0;
    end else if (ce) begin
      v1 <= valid_in;
      valid_out <= v1;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      for (int r = 0; r < 4; r++) begin
        prod[r][0] <= x * $signed(matrix[0][16*r +: 16]);
        prod[r][1] <= y * $signed(matrix[1][16*r +: 16]);
        prod[r][2] <= z * $signed(matrix[2][16*r +: 16]);
        trans[r]   <= {matrix[3][16*r +: 16], 16'h0000};
      end
      last1 <= last_in;
      last_out <= last1;
      rows <= {sums[0], sums[1], sums[2], sums[3]};
    end
  end

  always_comb begin
    for (int r = 0; r < 4; r++) begin
      sums[r] = RowW'(prod[r][0]) + RowW'(prod[r][1]) + RowW'(prod[r][2])
              + RowW'(trans[r]);
    end
  end

endmodule

[design/hvt_div_stage.sv]
// hvt_div_stage: one registered restoring-division step for three lanes.
// Depends on hvt_pkg.
module hvt_div_stage import hvt_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  input  logic      ce,
  input  logic      valid_in,
  input  div_item_t item_in,
  output logic      valid_out,
  output div_item_t item_out
);

  div_item_t item_next;
  logic [MagW:0] trial [3];

  always_comb begin
    item_next = item_in;
    for (int l = 0; l < 3; l++) begin
      trial[l] = {item_in.lane[l].rem, item_in.lane[l].nlo[QW-1]};
      item_next.lane[l].nlo = {item_in.lane[l].nlo[QW-2:0], 1'b0};
      if (trial[l] >= {1'b0, item_in.d}) begin
        item_next.lane[l].rem = MagW'(trial[l] - {1'b0, item_in.d});
        item_next.lane[l].q = {item_in.lane[l].q[QW-2:0], 1'b1};
      end else begin
        item_next.lane[l].rem = trial[l][MagW-1:0];
        item_next.lane[l].q = {item_in.lane[l].q[QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_out <= 1'b0;
    end else if (ce) begin
      valid_out <= valid_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      item_out <= item_next;
    end
  end

endmodule

[design/homogeneous_vertex_transform.sv]
// Homogeneous 4x4 vertex transform with perspective divide. One vertex is taken
// every cycle while the output is not stalled; each result passes through 36
// register stages: two multiply/add stages, one setup stage, a 32-stage
// bit-per-stage divider and an output register. A stall at the output holds the
// whole pipeline. Matrix columns are written through
// cfg_write/cfg_index/cfg_data.
// Depends on hvt_pkg, hvt_mac and hvt_div_stage.
module homogeneous_vertex_transform import hvt_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     cfg_write,
  input  logic [CfgIdxW-1:0]       cfg_index,
  input  logic [63:0]              cfg_data,
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic signed [CoordW-1:0] x_in,
  input  logic signed [CoordW-1:0] y_in,
  input  logic signed [CoordW-1:0] z_in,
  input  logic                     last_in,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic signed [CoordW-1:0] x_out,
  output logic signed [CoordW-1:0] y_out,
  output logic signed [CoordW-1:0] z_out,
  output logic [1:0]               status,
  output logic                     last_out
);

  logic [3:0][63:0] matrix;
  logic ce;
  logic mac_valid, mac_last;
  rows_t rows;
  logic signed [RowW-1:0] num [3];
  logic [MagW-1:0] wmag;
  logic [MagW-1:0] nmag [3];
  div_item_t prep_next;
  logic      dv [NumDivSteps+1];
  div_item_t di [NumDivSteps+1];
  logic [QW-1:0] res [3];
  logic sat_any;

  assign ce = !out_valid || !out_stall;
  assign in_stall = !ce;

  always_ff @(posedge clk) begin
    if (rst) begin
      matrix[0] <= ResetCol0;
      matrix[1] <= ResetCol1;
      matrix[2] <= ResetCol2;
      matrix[3] <= ResetCol3;
    end else if (cfg_write) begin
      case (cfg_index)
        RegCol0: matrix[0] <= cfg_data;
        RegCol1: matrix[1] <= cfg_data;
        RegCol2: matrix[2] <= cfg_data;
        RegCol3: matrix[3] <= cfg_data;
        default: ;
      endcase
    end
  end

  hvt_mac u_mac (
    .clk       (clk),
    .rst       (rst),
    .ce        (ce),
    .valid_in  (in_valid),
    .x         (x_in),
    .y         (y_in),
    .z         (z_in),
    .last_in   (last_in),
    .matrix    (matrix),
    .valid_out (mac_valid),
    .rows      (rows),
    .last_out  (mac_last)
  );

  // setup: magnitudes, signs, overflow test
  always_comb begin
    num[0] = rows.r0;
    num[1] = rows.r1;
    num[2] = rows.r2;
    wmag = rows.r3[RowW-1] ? MagW'(-rows.r3) : MagW'(rows.r3);
    prep_next.d = wmag;
    prep_next.wz = (rows.r3 == '0);
    prep_next.last = mac_last;
    for (int l = 0; l < 3; l++) begin
      nmag[l] = num[l][RowW-1] ? MagW'(-num[l]) : MagW'(num[l]);
      prep_next.lane[l].rem = {16'h0000, nmag[l][MagW-1:16]};
      prep_next.lane[l].nlo = {nmag[l][15:0], 16'h0000};
      prep_next.lane[l].q = '0;
      prep_next.lane[l].neg = num[l][RowW-1] ^ rows.r3[RowW-1];
      prep_next.lane[l].ovf = ({16'h0000, nmag[l][MagW-1:16]} >= wmag);
      prep_next.lane[l].npos = !num[l][RowW-1] && (num[l] != '0);
      prep_next.lane[l].nneg = num[l][RowW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (ce) begin
      dv[0] <= mac_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      di[0] <= prep_next;
    end
  end

  for (genvar k = 0; k < NumDivSteps; k++) begin : g_div
    hvt_div_stage u_stage (
      .clk       (clk),
      .rst       (rst),
      .ce        (ce),
      .valid_in  (dv[k]),
      .item_in   (di[k]),
      .valid_out (dv[k+1]),
      .item_out  (di[k+1])
    );
  end

  always_comb begin
    sat_any = 1'b0;
    for (int l = 0; l < 3; l++) begin
      if (di[NumDivSteps].wz) begin
        res[l] = di[NumDivSteps].lane[l].npos ? QMaxPos :
                 di[NumDivSteps].lane[l].nneg ? QMaxNeg : '0;
      end else if (di[NumDivSteps].lane[l].neg) begin
        if (di[NumDivSteps].lane[l].ovf || di[NumDivSteps].lane[l].q > QMaxNeg) begin
          res[l] = QMaxNeg;
          sat_any = 1'b1;
        end else begin
          res[l] = -di[NumDivSteps].lane[l].q;
        end
      end else begin
        if (di[NumDivSteps].lane[l].ovf || di[NumDivSteps].lane[l].q[QW-1]) begin
          res[l] = QMaxPos;
          sat_any = 1'b1;
        end else begin
          res[l] = di[NumDivSteps].lane[l].q;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (ce) begin
      out_valid <= dv[NumDivSteps];
    end
  end

  always_ff @(posedge clk) begin
    if (ce) begin
      x_out <= res[0];
      y_out <= res[1];
      z_out <= res[2];
      status <= di[NumDivSteps].wz ? StatusWZero : (sat_any ? StatusSat : StatusOk);
      last_out <= di[NumDivSteps].last;
    end
  end

endmodule

[tb/tb.sv]
// Testbench for homogeneous_vertex_transform: drives vertices and matrix writes,
// predicts each transformed point and checks results in order.
// Depends on hvt_pkg and the homogeneous_vertex_transform RTL.
module tb;
  import hvt_pkg::*;

  typedef struct {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] z;
    logic [1:0]  st;
    logic        last;
  } point_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [CfgIdxW-1:0] cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [31:0] x_in = '0, y_in = '0, z_in = '0;
  logic last_in = 1'b0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] x_out, y_out, z_out;
  logic [1:0] status;
  logic last_out;

  logic [63:0] matrix [4];
  point_t expected_points[$];
  int errors = 0;
  int idle_cycles = 0;
  bit stall_random = 1'b1;
  bit send_gaps = 1'b1;

  homogeneous_vertex_transform u_dut (.*);

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  function automatic logic signed [63:0] coef(int c, int r);
    return 64'(signed'(matrix[c][16*r +: 16]));
  endfunction

  function automatic logic [31:0] quotient(logic signed [63:0] n, logic signed [63:0] w,
                                           inout bit sat);
    logic [63:0] mn, mw, q;
    bit neg;
    if (w == 0) return n > 0 ? QMaxPos : (n < 0 ? QMaxNeg : 32'd0);
    neg = (n < 0) != (w < 0);
    mn = n < 0 ? -n : n;
    mw = w < 0 ? -w : w;
    q = (mn << 16) / mw;
    if (neg) begin
      if (q > 64'h8000_0000) begin
        sat = 1'b1;
        q = 64'h8000_0000;
      end
      return 32'(-q);
    end
    if (q > 64'h7FFF_FFFF) begin
      sat = 1'b1;
      q = 64'h7FFF_FFFF;
    end
    return q[31:0];
  endfunction

  function automatic point_t transform(logic signed [31:0] x, logic signed [31:0] y,
                                       logic signed [31:0] z, logic l);
    logic signed [63:0] row [4];
    point_t p;
    bit sat;
    sat = 1'b0;
    for (int r = 0; r < 4; r++)
      row[r] = 64'(x) * coef(0, r) + 64'(y) * coef(1, r) + 64'(z) * coef(2, r)
             + coef(3, r) * 64'sd65536;
    p.x = quotient(row[0], row[3], sat);
    p.y = quotient(row[1], row[3], sat);
    p.z = quotient(row[2], row[3], sat);
    p.st = row[3] == 0 ? StatusWZero : (sat ? StatusSat : StatusOk);
    p.last = l;
    return p;
  endfunction

  task automatic report(string what, logic [31:0] got, logic [31:0] want);
    $display("MISMATCH %s: got %h want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  // result checker
  always @(posedge clk) begin
    point_t e;
    if (!rst && out_valid && !out_stall) begin
      if (expected_points.size() == 0) begin
        report("unexpected transaction", 0, 0);
      end else begin
        e = expected_points.pop_front();
        if (x_out !== e.x) report("x_out", x_out, e.x);
        if (y_out !== e.y) report("y_out", y_out, e.y);
        if (z_out !== e.z) report("z_out", z_out, e.z);
        if (status !== e.st) report("status", status, e.st);
        if (last_out !== e.last) report("last_out", last_out, e.last);
      end
    end
  end

  // output stall bursts
  always @(posedge clk) begin
    if (!stall_random) begin
      out_stall <= 1'b0;
    end else if ($urandom_range(0, 15) == 0) begin
      out_stall <= 1'b1;
      repeat ($urandom_range(1, 9)) @(posedge clk);
      out_stall <= 1'b0;
    end
  end

  // watchdog
  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > 5000) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic send_vertex(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic l);
    if (send_gaps && $urandom_range(0, 15) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_valid <= 1'b1;
    x_in <= x;
    y_in <= y;
    z_in <= z;
    last_in <= l;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    expected_points.push_back(transform(x, y, z, l));
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (expected_points.size() != 0) @(posedge clk);
    repeat (45) @(posedge clk);
  endtask

  task automatic write_column(logic [CfgIdxW-1:0] idx, logic [63:0] val);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    if (idx < 4) matrix[idx] = val;
    @(posedge clk);
  endtask

  function automatic logic [31:0] rand_coord();
    case ($urandom_range(0, 5))
      0: return 32'h7FFF_FFFF;
      1: return 32'h8000_0000;
      2: return $urandom_range(0, 255) << 16;
      3: return -($urandom_range(0, 255) << 16);
      default: return $urandom;
    endcase
  endfunction

  function automatic logic [15:0] rand_coef();
    case ($urandom_range(0, 4))
      0: return 16'h7FFF;
      1: return 16'h8000;
      2: return 16'($urandom_range(0, 8192)) - 16'd4096;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic test_identity();
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0000_8000, 1'b0);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1);
    send_vertex(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b0);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b1);
    send_vertex(32'hFFFF_FFFF, 32'h0000_0001, 32'h5555_AAAA, 1'b0);
    drain();
  endtask

  task automatic test_w_zero();
    write_column(RegCol3, 64'h0000_0000_0000_0000);
    send_vertex(32'h0001_0000, 32'hFFFF_0000, 32'h0, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    drain();
    write_column(RegCol3, 64'h0000_0000_0000_1000);
    write_column(RegCol2, 64'h1000_0000_0000_0000);
    send_vertex(32'h0002_0000, 32'h0003_0000, 32'h0, 1'b0);
    send_vertex(32'h0002_0000, 32'h0003_0000, 32'h0001_0000, 1'b1);
    send_vertex(32'h0002_0000, 32'h0003_0000, 32'hFFFF_0000, 1'b0);
    drain();
  endtask

  task automatic test_saturation();
    write_column(RegCol0, 64'h0000_0000_7FFF_7FFF);
    write_column(RegCol1, 64'h0000_8000_8000_0000);
    write_column(RegCol2, 64'h0001_0000_0000_0000);
    write_column(RegCol3, 64'h0001_7FFF_8000_7FFF);
    send_vertex(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 1'b0);
    send_vertex(32'h8000_0000, 32'h7FFF_FFFF, 32'h0000_0001, 1'b1);
    send_vertex(32'h0, 32'h0, 32'h0, 1'b0);
    send_vertex(32'h0, 32'h0, 32'hFFFF_FFFF, 1'b0);
    drain();
    write_column(3'd5, 64'hFFFF_FFFF_FFFF_FFFF);
    write_column(3'd7, 64'h0);
    send_vertex(32'h1234_5678, 32'h8765_4321, 32'h0, 1'b1);
    drain();
  endtask

  task automatic test_random(int n);
    for (int i = 0; i < n; i++) begin
      if (i % 200 == 0) begin
        drain();
        for (int c = 0; c < 4; c++)
          write_column(c[CfgIdxW-1:0], {rand_coef(), rand_coef(), rand_coef(), rand_coef()});
        if ($urandom_range(0, 3) == 0)
          write_column(CfgIdxW'($urandom_range(4, 7)), {$urandom, $urandom});
      end
      send_vertex(rand_coord(), rand_coord(), rand_coord(), 1'($urandom));
    end
    drain();
  endtask

  task automatic test_full_rate(int n);
    stall_random = 1'b0;
    send_gaps = 1'b0;
    for (int i = 0; i < n; i++)
      send_vertex($urandom, $urandom, $urandom, 1'($urandom));
    drain();
  endtask

  initial begin
    matrix[0] = ResetCol0;
    matrix[1] = ResetCol1;
    matrix[2] = ResetCol2;
    matrix[3] = ResetCol3;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_identity();
    test_w_zero();
    test_saturation();
    test_random(1500);
    test_full_rate(200);
    if (errors == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end
endmodule

[files.f]
design/hvt_pkg.sv
design/hvt_mac.sv
design/hvt_div_stage.sv
design/homogeneous_vertex_transform.sv
tb/tb.sv
